FILE: hdl/flvs_pkg.sv
// shared types and constants of the flash log variable store
package flvs_pkg;

    // store geometry
    localparam int DEPTH    = 1024;
    localparam int AW       = $clog2(DEPTH);
    localparam int PW       = AW + 1;
    localparam int NUM_VARS = 1;
    localparam int VW       = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

    // record layout and flash words
    localparam logic [7:0]  REC_TAG     = 8'hA5;
    localparam logic [31:0] ERASED_WORD = 32'hFFFF_FFFF;
    localparam logic [7:0]  FAIL_MAX    = 8'hFF;

    // request codes
    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_ERASE = 2'd2,
        REQ_MOUNT = 2'd3
    } t_req;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DEFAULT  = 2'd1,
        ST_PROG_ERR = 2'd2
    } t_status;

    // commands from controller to datapath
    typedef struct packed {
        logic    ld_req;
        logic    key_var;
        logic    sp_load_wp;
        logic    sp_load_top;
        logic    rd_search;
        logic    take_found;
        logic    take_default;
        logic    save_var;
        logic    wp_clear;
        logic    wp_from_sp;
        logic    fresh_set;
        logic    fresh_clr;
        logic    var_clr;
        logic    var_inc;
        logic    prog_rd;
        logic    prog_wr;
        logic    prog_saved;
        logic    bad_clr;
        logic    out_valid;
        t_status out_status;
        logic    out_zero;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic sp_zero;
        logic hit;
        logic erased;
        logic wp_zero;
        logic wp_full;
        logic fresh;
        logic var_last;
        logic bad;
    } t_stat;

endpackage

FILE: hdl/flvs_dp.sv
// datapath: record memory, pointers, search compare, result registers
module flvs_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  flvs_pkg::t_cmd   i_cmd,
    output flvs_pkg::t_stat  o_stat,
    input  logic             i_cfg_we,
    input  logic [15:0]      i_cfg_wdata,
    input  logic [7:0]       i_var_index,
    input  logic [15:0]      i_write_value,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [15:0]      o_read_value,
    output logic [7:0]       o_error_count
);
    import flvs_pkg::*;

    // record memory; entries at or above the write pointer count as erased
    logic [31:0] mem [DEPTH];
    logic [15:0] saved [NUM_VARS];

    logic [PW-1:0] r_wp, r_sp;
    logic [7:0]    r_var, r_idx, r_fail;
    logic [15:0]   r_val, r_rval, r_default, r_saved_q;
    logic [31:0]   r_rdata;
    logic          r_oor, r_fresh, r_bad;
    logic          r_done;
    t_status       r_status;
    logic [15:0]   r_out_val;

    logic [PW-1:0] sp_m1;
    logic [AW-1:0] rd_addr;
    logic          rd_en, wr_en, erased, full;
    logic [7:0]    key, prog_idx;
    logic [15:0]   prog_val;
    logic [31:0]   rec;

    // address and record assembly
    always_comb begin
        sp_m1    = r_sp - PW'(1);
        rd_en    = i_cmd.rd_search | i_cmd.prog_rd;
        rd_addr  = i_cmd.prog_rd ? r_wp[AW-1:0] : sp_m1[AW-1:0];
        key      = i_cmd.key_var ? r_var : r_idx;
        full     = (r_wp >= PW'(DEPTH));
        erased   = r_oor | (r_rdata == ERASED_WORD);
        prog_idx = i_cmd.prog_saved ? r_var : r_idx;
        prog_val = i_cmd.prog_saved ? r_saved_q : r_val;
        rec      = {prog_val, prog_idx, REC_TAG};
        wr_en    = i_cmd.prog_wr & ~full & erased;
    end

    // memory port, read data registered
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_wp[AW-1:0]] <= rec;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
            r_oor   <= ({1'b0, rd_addr} >= r_wp);
        end
    end

    // saved live values during compaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.save_var) begin
            saved[r_var[VW-1:0]] <= r_rval;
        end
        if (i_cmd.prog_rd) begin
            r_saved_q <= saved[r_var[VW-1:0]];
        end
    end

    // request payload and search result
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_req) begin
            r_idx <= i_var_index;
            r_val <= i_write_value;
        end
        if (i_cmd.take_found) begin
            r_rval <= r_rdata[31:16];
        end else if (i_cmd.take_default) begin
            r_rval <= ({1'b0, key} < 9'(NUM_VARS)) ? r_default : 16'd0;
        end
        if (i_cmd.out_valid) begin
            r_status  <= i_cmd.out_status;
            r_out_val <= i_cmd.out_zero ? 16'd0 : r_rval;
        end
    end

    // pointers, counters and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_sp      <= '0;
            r_var     <= '0;
            r_fail    <= '0;
            r_fresh   <= 1'b0;
            r_bad     <= 1'b0;
            r_done    <= 1'b0;
            r_default <= 16'd1;
        end else begin
            r_done <= i_cmd.out_valid;
            if (i_cfg_we) begin
                r_default <= i_cfg_wdata;
            end
            if (i_cmd.wp_clear) begin
                r_wp <= '0;
            end else if (i_cmd.wp_from_sp) begin
                r_wp <= r_sp + PW'(1);
            end else if (i_cmd.prog_wr && !full) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_cmd.sp_load_wp) begin
                r_sp <= r_wp;
            end else if (i_cmd.sp_load_top) begin
                r_sp <= PW'(DEPTH);
            end else if (i_cmd.rd_search) begin
                r_sp <= sp_m1;
            end
            if (i_cmd.var_clr) begin
                r_var <= '0;
            end else if (i_cmd.var_inc) begin
                r_var <= r_var + 8'd1;
            end
            if (i_cmd.fresh_set) begin
                r_fresh <= 1'b1;
            end else if (i_cmd.fresh_clr) begin
                r_fresh <= 1'b0;
            end
            if (i_cmd.bad_clr) begin
                r_bad <= 1'b0;
            end else if (i_cmd.prog_wr && (full || !erased)) begin
                r_bad <= 1'b1;
            end
            // program onto a non-blank word, saturating
            if (i_cmd.prog_wr && !full && !erased && r_fail != FAIL_MAX) begin
                r_fail <= r_fail + 8'd1;
            end
        end
    end

    // status back to the controller
    always_comb begin
        o_stat.sp_zero  = (r_sp == '0);
        o_stat.hit      = ~r_oor & (r_rdata[7:0] == REC_TAG) & (r_rdata[15:8] == key);
        o_stat.erased   = erased;
        o_stat.wp_zero  = (r_wp == '0);
        o_stat.wp_full  = full;
        o_stat.fresh    = r_fresh;
        o_stat.var_last = (r_var == 8'(NUM_VARS - 1));
        o_stat.bad      = r_bad;
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_read_value  = r_out_val;
    assign o_error_count = r_fail;

endmodule

FILE: hdl/flvs_ctrl.sv
// controller: sequences read, write with compaction, erase and mount
module flvs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [1:0]       i_req_type,
    input  flvs_pkg::t_stat  i_stat,
    output flvs_pkg::t_cmd   o_cmd,
    output logic             o_busy
);
    import flvs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH_ISSUE, S_SRCH_CHECK, S_SAVE, S_PROG_RD, S_PROG_WR,
        S_MNT_ISSUE, S_MNT_CHECK, S_MNT_LOAD, S_REPLY
    } t_state;

    typedef enum logic [2:0] {
        M_READ, M_WRITE, M_ERASE, M_MOUNT, M_MOUNT_EMPTY, M_COMPACT
    } t_mode;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic   r_hit, n_hit;
    logic   r_prog_saved, n_prog_saved;

    // next state and command decode
    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_hit        = r_hit;
        n_prog_saved = r_prog_saved;
        o_cmd            = '0;
        o_cmd.out_status = ST_OK;
        o_cmd.key_var    = (r_mode == M_COMPACT) || (r_mode == M_MOUNT);
        o_cmd.prog_saved = r_prog_saved;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.ld_req = 1'b1;
                    unique case (t_req'(i_req_type))
                        REQ_READ: begin
                            n_mode           = M_READ;
                            o_cmd.sp_load_wp = 1'b1;
                            n_state          = S_SRCH_ISSUE;
                        end
                        REQ_WRITE: begin
                            n_mode        = M_WRITE;
                            n_prog_saved  = 1'b0;
                            o_cmd.bad_clr = 1'b1;
                            if (i_stat.wp_zero && i_stat.fresh) begin
                                o_cmd.fresh_clr = 1'b1;
                                n_state         = S_PROG_RD;
                            end else if (i_stat.wp_zero || i_stat.wp_full) begin
                                n_mode           = M_COMPACT;
                                o_cmd.var_clr    = 1'b1;
                                o_cmd.sp_load_wp = 1'b1;
                                n_state          = S_SRCH_ISSUE;
                            end else begin
                                n_state = S_PROG_RD;
                            end
                        end
                        REQ_ERASE: begin
                            n_mode          = M_ERASE;
                            o_cmd.wp_clear  = 1'b1;
                            o_cmd.fresh_set = 1'b1;
                            n_state         = S_REPLY;
                        end
                        REQ_MOUNT: begin
                            n_mode            = M_MOUNT;
                            o_cmd.var_clr     = 1'b1;
                            o_cmd.sp_load_top = 1'b1;
                            n_state           = S_MNT_ISSUE;
                        end
                    endcase
                end
            end
            // backward search, one memory word per issue and check
            S_SRCH_ISSUE: begin
                if (i_stat.sp_zero) begin
                    o_cmd.take_default = 1'b1;
                    n_hit              = 1'b0;
                    n_state            = (r_mode == M_COMPACT) ? S_SAVE : S_REPLY;
                end else begin
                    o_cmd.rd_search = 1'b1;
                    n_state         = S_SRCH_CHECK;
                end
            end
            S_SRCH_CHECK: begin
                if (i_stat.hit) begin
                    o_cmd.take_found = 1'b1;
                    n_hit            = 1'b1;
                    n_state          = (r_mode == M_COMPACT) ? S_SAVE : S_REPLY;
                end else begin
                    n_state = S_SRCH_ISSUE;
                end
            end
            // keep a live value, then search the next one or erase
            S_SAVE: begin
                o_cmd.save_var = 1'b1;
                if (i_stat.var_last) begin
                    o_cmd.wp_clear = 1'b1;
                    o_cmd.var_clr  = 1'b1;
                    n_prog_saved   = 1'b1;
                    n_state        = S_PROG_RD;
                end else begin
                    o_cmd.var_inc    = 1'b1;
                    o_cmd.sp_load_wp = 1'b1;
                    n_state          = S_SRCH_ISSUE;
                end
            end
            // blank check then program
            S_PROG_RD: begin
                o_cmd.prog_rd = 1'b1;
                n_state       = S_PROG_WR;
            end
            S_PROG_WR: begin
                o_cmd.prog_wr = 1'b1;
                if (r_prog_saved) begin
                    if (i_stat.var_last) begin
                        n_prog_saved = 1'b0;
                        n_mode       = M_WRITE;
                    end else begin
                        o_cmd.var_inc = 1'b1;
                    end
                    n_state = S_PROG_RD;
                end else begin
                    n_state = S_REPLY;
                end
            end
            // mount: scan from the top for the last used word
            S_MNT_ISSUE: begin
                if (i_stat.sp_zero) begin
                    o_cmd.wp_clear     = 1'b1;
                    o_cmd.fresh_set    = 1'b1;
                    o_cmd.key_var      = 1'b1;
                    o_cmd.take_default = 1'b1;
                    n_mode             = M_MOUNT_EMPTY;
                    n_state            = S_REPLY;
                end else begin
                    o_cmd.rd_search = 1'b1;
                    n_state         = S_MNT_CHECK;
                end
            end
            S_MNT_CHECK: begin
                if (!i_stat.erased) begin
                    o_cmd.wp_from_sp = 1'b1;
                    n_state          = S_MNT_LOAD;
                end else begin
                    n_state = S_MNT_ISSUE;
                end
            end
            S_MNT_LOAD: begin
                o_cmd.sp_load_wp = 1'b1;
                n_state          = S_SRCH_ISSUE;
            end
            // one result transaction
            S_REPLY: begin
                o_cmd.out_valid = 1'b1;
                n_state         = S_IDLE;
                case (r_mode)
                    M_READ: begin
                        o_cmd.out_status = r_hit ? ST_OK : ST_DEFAULT;
                    end
                    M_WRITE: begin
                        o_cmd.out_status = i_stat.bad ? ST_PROG_ERR : ST_OK;
                        o_cmd.out_zero   = 1'b1;
                    end
                    M_ERASE: begin
                        o_cmd.out_status = ST_DEFAULT;
                        o_cmd.out_zero   = 1'b1;
                    end
                    M_MOUNT_EMPTY: begin
                        o_cmd.out_status = ST_DEFAULT;
                    end
                    default: begin
                        o_cmd.out_status = ST_OK;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and mode registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= M_READ;
            r_hit        <= 1'b0;
            r_prog_saved <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_hit        <= n_hit;
            r_prog_saved <= n_prog_saved;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: hdl/flash_log_variable_store_top.sv
// top level of the flash log variable store
//
//  channel   handshake           payload
//  request   i_start / o_busy    i_req_type, i_var_index, i_write_value
//  result    o_done strobe       o_status, o_read_value, o_error_count
//  config    i_cfg_we            i_cfg_wdata (default value)
//
// a transaction is taken when i_start is high and o_busy low; one result
// follows as a one-cycle o_done pulse, which the receiver cannot stall.
// read: a backward search from the write pointer, one memory word at a time.
// write: blank check then program; compaction first copies every variable back.
// mount: a scan down from the top for the last used word, then a read of variable 0.
// reset is synchronous; the write pointer doubles as a fill mark, so
// words at or above it read as erased and no clearing pass is needed.
module flash_log_variable_store_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_var_index,
    input  logic [15:0] i_write_value,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [15:0] o_read_value,
    output logic [7:0]  o_error_count,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);
    import flvs_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    flvs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (o_busy)
    );

    // memory and arithmetic
    flvs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_var_index   (i_var_index),
        .i_write_value (i_write_value),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_error_count (o_error_count)
    );

endmodule

FILE: hdl/flvs_checker.sv
// port-level checker for the flash log variable store, with its bind
module flvs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_done,
    input logic [1:0]  o_status,
    input logic [7:0]  o_error_count
);
    import flvs_pkg::*;

    // an accepted transaction makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted transaction did not raise busy");

    // busy ends exactly with a result
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_busy ##1 !o_busy) |-> o_done)
        else $error("busy dropped without a result");

    // results never come back to back
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held over two cycles");

    // status code is meaningful
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == ST_OK || o_status == ST_DEFAULT ||
                    o_status == ST_PROG_ERR))
        else $error("undefined status code");

    // error count only grows
    a_err_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (o_error_count >= $past(o_error_count)))
        else $error("error count went down");

endmodule

bind flash_log_variable_store_top flvs_checker u_flvs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .o_busy        (o_busy),
    .o_done        (o_done),
    .o_status      (o_status),
    .o_error_count (o_error_count)
);
